[rtl/tpp_pkg.sv]
// Shared types, opcodes and constants for the turtle pen plotter.
`timescale 1ns / 1ps
package tpp_pkg;

	localparam int GRID_SIZE_DEF = 32;
	localparam int MAX_ROWS      = 32;
	localparam int ROW_BITS      = 32;
	localparam int IDX_W         = 5;
	localparam int KIND_W        = 3;
	localparam int STEPS_W       = 8;
	localparam int HEAD_W        = 2;
	localparam int QDEPTH        = 2;

	localparam logic [KIND_W-1:0] K_PEN_UP   = 3'd0;
	localparam logic [KIND_W-1:0] K_PEN_DOWN = 3'd1;
	localparam logic [KIND_W-1:0] K_RIGHT    = 3'd2;
	localparam logic [KIND_W-1:0] K_LEFT     = 3'd3;
	localparam logic [KIND_W-1:0] K_MOVE     = 3'd4;
	localparam logic [KIND_W-1:0] K_DUMP     = 3'd5;

	localparam logic [2:0] OP_NOP      = 3'd0;
	localparam logic [2:0] OP_PEN_UP   = 3'd1;
	localparam logic [2:0] OP_PEN_DOWN = 3'd2;
	localparam logic [2:0] OP_RIGHT    = 3'd3;
	localparam logic [2:0] OP_LEFT     = 3'd4;
	localparam logic [2:0] OP_MOVE     = 3'd5;
	localparam logic [2:0] OP_DUMP     = 3'd6;

	localparam logic [HEAD_W-1:0] H_EAST  = 2'd0;
	localparam logic [HEAD_W-1:0] H_SOUTH = 2'd1;
	localparam logic [HEAD_W-1:0] H_WEST  = 2'd2;
	localparam logic [HEAD_W-1:0] H_NORTH = 2'd3;

	typedef struct packed {
		logic [2:0]         op;
		logic [STEPS_W-1:0] steps;
	} cmd_t;

endpackage

[rtl/tpp_front.sv]
// Command front end: accepts commands and classifies them into opcodes.
`timescale 1ns / 1ps
module tpp_front (
	input  logic                       start,
	input  logic [tpp_pkg::KIND_W-1:0] kind,
	input  logic [tpp_pkg::STEPS_W-1:0] steps,
	input  logic                       q_full,
	output logic                       busy,
	output logic                       push,
	output tpp_pkg::cmd_t              cmd
);

	assign busy = q_full;
	assign push = start && !q_full;

	always_comb begin
		cmd.steps = steps;
		case (kind)
			tpp_pkg::K_PEN_UP:   cmd.op = tpp_pkg::OP_PEN_UP;
			tpp_pkg::K_PEN_DOWN: cmd.op = tpp_pkg::OP_PEN_DOWN;
			tpp_pkg::K_RIGHT:    cmd.op = tpp_pkg::OP_RIGHT;
			tpp_pkg::K_LEFT:     cmd.op = tpp_pkg::OP_LEFT;
			tpp_pkg::K_MOVE:     cmd.op = (steps == '0) ? tpp_pkg::OP_NOP : tpp_pkg::OP_MOVE;
			tpp_pkg::K_DUMP:     cmd.op = tpp_pkg::OP_DUMP;
			default:             cmd.op = tpp_pkg::OP_NOP;
		endcase
	end

endmodule

[rtl/tpp_queue.sv]
// Two-entry command queue between front end and executor.
`timescale 1ns / 1ps
module tpp_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  tpp_pkg::cmd_t push_cmd,
	input  logic          pop,
	output tpp_pkg::cmd_t head_cmd,
	output logic          empty,
	output logic          full
);

	localparam int PTR_W = (tpp_pkg::QDEPTH > 1) ? $clog2(tpp_pkg::QDEPTH) : 1;
	localparam int CNT_W = $clog2(tpp_pkg::QDEPTH + 1);

	tpp_pkg::cmd_t     slot_q [tpp_pkg::QDEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_push;
	logic              do_pop;

	assign empty    = (count_q == '0);
	assign full     = (count_q == CNT_W'(tpp_pkg::QDEPTH));
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign head_cmd = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(tpp_pkg::QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(tpp_pkg::QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[rtl/tpp_back.sv]
// Command executor: turtle state, canvas memory, moves, dumps and results.
`timescale 1ns / 1ps
module tpp_back #(
	parameter int GRID_SIZE = tpp_pkg::GRID_SIZE_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         q_empty,
	input  tpp_pkg::cmd_t                head_cmd,
	output logic                         pop,
	output logic                         strobe,
	output logic                         is_row,
	output logic [tpp_pkg::IDX_W-1:0]    row_index,
	output logic [tpp_pkg::ROW_BITS-1:0] row_bits,
	output logic [tpp_pkg::IDX_W-1:0]    turtle_row,
	output logic [tpp_pkg::IDX_W-1:0]    turtle_col,
	output logic [tpp_pkg::HEAD_W-1:0]   heading,
	output logic                         pen_is_down,
	output logic                         last
);

	localparam int GRID_N = (GRID_SIZE > tpp_pkg::MAX_ROWS) ? tpp_pkg::MAX_ROWS :
	                        (GRID_SIZE < 2) ? 2 : GRID_SIZE;
	localparam int POS_W  = $clog2(GRID_N);
	localparam int DEPTH  = 2 ** POS_W;
	localparam logic [POS_W-1:0] POS_LAST = POS_W'(GRID_N - 1);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_STEP = 3'd1;
	localparam logic [2:0] S_MARK = 3'd2;
	localparam logic [2:0] S_DONE = 3'd3;
	localparam logic [2:0] S_DUMP = 3'd4;

	logic [2:0]                   state_q;
	logic [POS_W-1:0]             row_q;
	logic [POS_W-1:0]             col_q;
	logic [tpp_pkg::HEAD_W-1:0]   dir_q;
	logic                         pen_q;
	logic [tpp_pkg::STEPS_W-1:0]  cnt_q;
	logic [POS_W-1:0]             idx_q;

	logic [tpp_pkg::ROW_BITS-1:0] mem [DEPTH];
	logic [DEPTH-1:0]             vld_q;
	logic [tpp_pkg::ROW_BITS-1:0] rd_q;
	logic                         rdv_q;
	logic [tpp_pkg::ROW_BITS-1:0] rd_row;
	logic [POS_W-1:0]             rd_addr;
	logic                         wr_en;

	logic [POS_W-1:0]             nxt_row;
	logic [POS_W-1:0]             nxt_col;
	logic [tpp_pkg::HEAD_W-1:0]   nxt_dir;
	logic                         nxt_pen;

	assign pop    = (state_q == S_IDLE) && !q_empty;
	assign rd_row = rdv_q ? rd_q : '0;
	assign wr_en  = (state_q == S_MARK);

	always_comb begin
		nxt_row = row_q;
		nxt_col = col_q;
		case (dir_q)
			tpp_pkg::H_EAST:  if (col_q != POS_LAST) nxt_col = col_q + 1'b1;
			tpp_pkg::H_SOUTH: if (row_q != POS_LAST) nxt_row = row_q + 1'b1;
			tpp_pkg::H_WEST:  if (col_q != '0) nxt_col = col_q - 1'b1;
			default:          if (row_q != '0) nxt_row = row_q - 1'b1;
		endcase
	end

	always_comb begin
		nxt_dir = dir_q;
		nxt_pen = pen_q;
		case (head_cmd.op)
			tpp_pkg::OP_PEN_UP:   nxt_pen = 1'b0;
			tpp_pkg::OP_PEN_DOWN: nxt_pen = 1'b1;
			tpp_pkg::OP_RIGHT:    nxt_dir = dir_q + 1'b1;
			tpp_pkg::OP_LEFT:     nxt_dir = dir_q - 1'b1;
			default:              ;
		endcase
	end

	always_comb begin
		case (state_q)
			S_STEP:  rd_addr = nxt_row;
			S_DUMP:  rd_addr = idx_q + 1'b1;
			default: rd_addr = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[row_q] <= rd_row | (tpp_pkg::ROW_BITS'(1) << col_q);
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			rdv_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[row_q] <= 1'b1;
			end
			rdv_q <= vld_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			row_q   <= '0;
			col_q   <= '0;
			dir_q   <= tpp_pkg::H_EAST;
			pen_q   <= 1'b0;
			cnt_q   <= '0;
			idx_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (!q_empty) begin
						dir_q <= nxt_dir;
						pen_q <= nxt_pen;
						cnt_q <= head_cmd.steps;
						idx_q <= '0;
						if (head_cmd.op == tpp_pkg::OP_MOVE) begin
							state_q <= S_STEP;
						end else if (head_cmd.op == tpp_pkg::OP_DUMP) begin
							state_q <= S_DUMP;
						end
					end
				end
				S_STEP: begin
					row_q <= nxt_row;
					col_q <= nxt_col;
					cnt_q <= cnt_q - 1'b1;
					if (pen_q) begin
						state_q <= S_MARK;
					end else if (cnt_q == 8'd1) begin
						state_q <= S_DONE;
					end
				end
				S_MARK: begin
					state_q <= (cnt_q == '0) ? S_DONE : S_STEP;
				end
				S_DONE: begin
					state_q <= S_IDLE;
				end
				S_DUMP: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == POS_LAST) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe <= 1'b0;
		end else begin
			strobe <= (state_q == S_DUMP) || (state_q == S_DONE) ||
			          (pop && head_cmd.op != tpp_pkg::OP_MOVE && head_cmd.op != tpp_pkg::OP_DUMP);
		end
	end

	always_ff @(posedge clk) begin
		turtle_row <= tpp_pkg::IDX_W'(row_q);
		turtle_col <= tpp_pkg::IDX_W'(col_q);
		if (state_q == S_DUMP) begin
			is_row      <= 1'b1;
			row_index   <= tpp_pkg::IDX_W'(idx_q);
			row_bits    <= rd_row;
			heading     <= dir_q;
			pen_is_down <= pen_q;
			last        <= (idx_q == POS_LAST);
		end else begin
			is_row      <= 1'b0;
			row_index   <= '0;
			row_bits    <= '0;
			heading     <= (state_q == S_IDLE) ? nxt_dir : dir_q;
			pen_is_down <= (state_q == S_IDLE) ? nxt_pen : pen_q;
			last        <= 1'b1;
		end
	end

	a_mark_after_step: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_MARK |-> $past(state_q) == S_STEP)
		else $error("mark without preceding step");

	a_last_row: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && is_row && last |-> row_index == tpp_pkg::IDX_W'(GRID_N - 1))
		else $error("dump ended on wrong row");

	a_status_clean: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !is_row |-> row_bits == '0 && row_index == '0 && last)
		else $error("status result carries row data");

	a_pos_in_grid: assert property (@(posedge clk) disable iff (!arst_n)
		row_q <= POS_LAST && col_q <= POS_LAST)
		else $error("turtle left the grid");

	a_no_pop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> !pop)
		else $error("queue popped while executing");

endmodule

[rtl/turtle_pen_plotter_grid.sv]
// Pen, turn, zero-move and unknown-kind commands each give one status result on strobe.
// A move steps the turtle in STEP with the pen up, or STEP then MARK per step with the pen down
// (canvas RMW), then gives one status result. A dump returns rows from 0 up, one row per cycle.
// Commands enter a two-entry queue at one per cycle while it is not full; busy is high while it is full.
// Reset: turtle at row 0 column 0 heading east, pen up, queue empty, canvas row valid bits
// cleared at once so the canvas reads blank; results cannot be stalled by the receiver.
`timescale 1ns / 1ps
module turtle_pen_plotter_grid #(
	parameter int GRID_SIZE = tpp_pkg::GRID_SIZE_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [tpp_pkg::KIND_W-1:0]    kind,
	input  logic [tpp_pkg::STEPS_W-1:0]   steps,
	output logic                          busy,
	output logic                          strobe,
	output logic                          is_row,
	output logic [tpp_pkg::IDX_W-1:0]     row_index,
	output logic [tpp_pkg::ROW_BITS-1:0]  row_bits,
	output logic [tpp_pkg::IDX_W-1:0]     turtle_row,
	output logic [tpp_pkg::IDX_W-1:0]     turtle_col,
	output logic [tpp_pkg::HEAD_W-1:0]    heading,
	output logic                          pen_is_down,
	output logic                          last
);

	logic          push;
	logic          pop;
	logic          q_full;
	logic          q_empty;
	tpp_pkg::cmd_t push_cmd;
	tpp_pkg::cmd_t head_cmd;

	tpp_front u_front (
		.start  (start),
		.kind   (kind),
		.steps  (steps),
		.q_full (q_full),
		.busy   (busy),
		.push   (push),
		.cmd    (push_cmd)
	);

	tpp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head_cmd (head_cmd),
		.empty    (q_empty),
		.full     (q_full)
	);

	tpp_back #(
		.GRID_SIZE (GRID_SIZE)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.head_cmd    (head_cmd),
		.pop         (pop),
		.strobe      (strobe),
		.is_row      (is_row),
		.row_index   (row_index),
		.row_bits    (row_bits),
		.turtle_row  (turtle_row),
		.turtle_col  (turtle_col),
		.heading     (heading),
		.pen_is_down (pen_is_down),
		.last        (last)
	);

endmodule

[bench/turtle_pen_plotter_grid_tb.sv]
// Self-checking bench for the turtle pen plotter: directed and random commands, scoreboarded.
`timescale 1ns / 1ps
module turtle_pen_plotter_grid_tb;

	localparam int GRID = (tpp_pkg::GRID_SIZE_DEF > tpp_pkg::MAX_ROWS) ? tpp_pkg::MAX_ROWS :
		(tpp_pkg::GRID_SIZE_DEF < 2) ? 2 : tpp_pkg::GRID_SIZE_DEF;
	localparam logic [tpp_pkg::KIND_W-1:0] K_BAD_LO = 3'd6;
	localparam logic [tpp_pkg::KIND_W-1:0] K_BAD_HI = 3'd7;
	localparam int RUN_LIMIT_NS = 10_000_000;

	typedef struct packed {
		logic                         is_row;
		logic [tpp_pkg::IDX_W-1:0]    row_index;
		logic [tpp_pkg::ROW_BITS-1:0] row_bits;
		logic [tpp_pkg::IDX_W-1:0]    turtle_row;
		logic [tpp_pkg::IDX_W-1:0]    turtle_col;
		logic [tpp_pkg::HEAD_W-1:0]   heading;
		logic                         pen_is_down;
		logic                         last;
	} plot_report_t;

	class plot_scoreboard;
		logic [tpp_pkg::ROW_BITS-1:0] sheet [tpp_pkg::MAX_ROWS];
		logic [tpp_pkg::IDX_W-1:0]    pos_row;
		logic [tpp_pkg::IDX_W-1:0]    pos_col;
		logic [tpp_pkg::HEAD_W-1:0]   dir;
		logic                         pen;
		plot_report_t                 reports_q[$];
		int                           errors;

		function new();
			foreach (sheet[r])
				sheet[r] = '0;
			pos_row = '0;
			pos_col = '0;
			dir = tpp_pkg::H_EAST;
			pen = 1'b0;
			errors = 0;
		endfunction

		function plot_report_t snapshot(logic is_row, logic [tpp_pkg::IDX_W-1:0] idx,
			logic [tpp_pkg::ROW_BITS-1:0] bits, logic fin);
			plot_report_t rep;
			rep.is_row = is_row;
			rep.row_index = idx;
			rep.row_bits = bits;
			rep.turtle_row = pos_row;
			rep.turtle_col = pos_col;
			rep.heading = dir;
			rep.pen_is_down = pen;
			rep.last = fin;
			return rep;
		endfunction

		function void step_turtle(logic [tpp_pkg::STEPS_W-1:0] n);
			int i;
			for (i = 0; i < n; i++) begin
				case (dir)
					tpp_pkg::H_EAST:  if (pos_col + 1 < GRID) pos_col++;
					tpp_pkg::H_SOUTH: if (pos_row + 1 < GRID) pos_row++;
					tpp_pkg::H_WEST:  if (pos_col > 0) pos_col--;
					default:          if (pos_row > 0) pos_row--;
				endcase
				if (pen)
					sheet[pos_row][pos_col] = 1'b1;
			end
		endfunction

		function void note_command(logic [tpp_pkg::KIND_W-1:0] k,
			logic [tpp_pkg::STEPS_W-1:0] n);
			int r;
			case (k)
				tpp_pkg::K_PEN_UP:   pen = 1'b0;
				tpp_pkg::K_PEN_DOWN: pen = 1'b1;
				tpp_pkg::K_RIGHT:    dir = dir + 2'd1;
				tpp_pkg::K_LEFT:     dir = dir - 2'd1;
				tpp_pkg::K_MOVE:     step_turtle(n);
				tpp_pkg::K_DUMP: begin
					for (r = 0; r < GRID; r++)
						reports_q.push_back(snapshot(1'b1, r[tpp_pkg::IDX_W-1:0], sheet[r],
							r == GRID - 1));
					return;
				end
				default: ;
			endcase
			reports_q.push_back(snapshot(1'b0, '0, '0, 1'b1));
		endfunction

		function void report_field(string field, logic [tpp_pkg::ROW_BITS-1:0] want,
			logic [tpp_pkg::ROW_BITS-1:0] got);
			$display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
			errors++;
		endfunction

		function void check_result(plot_report_t got);
			plot_report_t want;
			if (reports_q.size() == 0) begin
				$display("%0t: unexpected result, expected none actual %0h", $time, got);
				errors++;
				return;
			end
			want = reports_q.pop_front();
			if (got.is_row !== want.is_row)
				report_field("is_row", tpp_pkg::ROW_BITS'(want.is_row),
					tpp_pkg::ROW_BITS'(got.is_row));
			if (got.row_index !== want.row_index)
				report_field("row_index", tpp_pkg::ROW_BITS'(want.row_index),
					tpp_pkg::ROW_BITS'(got.row_index));
			if (got.row_bits !== want.row_bits)
				report_field("row_bits", want.row_bits, got.row_bits);
			if (got.turtle_row !== want.turtle_row)
				report_field("turtle_row", tpp_pkg::ROW_BITS'(want.turtle_row),
					tpp_pkg::ROW_BITS'(got.turtle_row));
			if (got.turtle_col !== want.turtle_col)
				report_field("turtle_col", tpp_pkg::ROW_BITS'(want.turtle_col),
					tpp_pkg::ROW_BITS'(got.turtle_col));
			if (got.heading !== want.heading)
				report_field("heading", tpp_pkg::ROW_BITS'(want.heading),
					tpp_pkg::ROW_BITS'(got.heading));
			if (got.pen_is_down !== want.pen_is_down)
				report_field("pen_is_down", tpp_pkg::ROW_BITS'(want.pen_is_down),
					tpp_pkg::ROW_BITS'(got.pen_is_down));
			if (got.last !== want.last)
				report_field("last", tpp_pkg::ROW_BITS'(want.last),
					tpp_pkg::ROW_BITS'(got.last));
		endfunction

		function int pending();
			return reports_q.size();
		endfunction
	endclass

	logic                         clk;
	logic                         arst_n = 1'b0;
	logic                         start = 1'b0;
	logic [tpp_pkg::KIND_W-1:0]   kind = tpp_pkg::K_PEN_UP;
	logic [tpp_pkg::STEPS_W-1:0]  steps = '0;
	logic                         busy;
	logic                         strobe;
	logic                         is_row;
	logic [tpp_pkg::IDX_W-1:0]    row_index;
	logic [tpp_pkg::ROW_BITS-1:0] row_bits;
	logic [tpp_pkg::IDX_W-1:0]    turtle_row;
	logic [tpp_pkg::IDX_W-1:0]    turtle_col;
	logic [tpp_pkg::HEAD_W-1:0]   heading;
	logic                         pen_is_down;
	logic                         last;

	plot_scoreboard sb = new();
	int idle_pct = 0;

	turtle_pen_plotter_grid u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.kind        (kind),
		.steps       (steps),
		.busy        (busy),
		.strobe      (strobe),
		.is_row      (is_row),
		.row_index   (row_index),
		.row_bits    (row_bits),
		.turtle_row  (turtle_row),
		.turtle_col  (turtle_col),
		.heading     (heading),
		.pen_is_down (pen_is_down),
		.last        (last)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (strobe)
				sb.check_result({is_row, row_index, row_bits, turtle_row, turtle_col,
					heading, pen_is_down, last});
			if (start && !busy)
				sb.note_command(kind, steps);
		end
	end

	task automatic send_cmd(input logic [tpp_pkg::KIND_W-1:0] k,
		input logic [tpp_pkg::STEPS_W-1:0] n);
		kind <= k;
		steps <= n;
		start <= 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			kind <= tpp_pkg::KIND_W'($urandom);
			steps <= tpp_pkg::STEPS_W'($urandom);
			@(posedge clk);
			while ($urandom_range(99) < idle_pct)
				@(posedge clk);
		end
	endtask

	task automatic send_random_cmd();
		int pick;
		int span;
		logic [tpp_pkg::STEPS_W-1:0] junk;
		pick = $urandom_range(99);
		junk = tpp_pkg::STEPS_W'($urandom);
		if (pick < 8)
			send_cmd(tpp_pkg::K_PEN_UP, junk);
		else if (pick < 22)
			send_cmd(tpp_pkg::K_PEN_DOWN, junk);
		else if (pick < 34)
			send_cmd(tpp_pkg::K_RIGHT, junk);
		else if (pick < 46)
			send_cmd(tpp_pkg::K_LEFT, junk);
		else if (pick < 88) begin
			span = $urandom_range(99);
			if (span < 80)
				send_cmd(tpp_pkg::K_MOVE, tpp_pkg::STEPS_W'($urandom_range(12)));
			else if (span < 95)
				send_cmd(tpp_pkg::K_MOVE, tpp_pkg::STEPS_W'($urandom_range(64, 13)));
			else
				send_cmd(tpp_pkg::K_MOVE, tpp_pkg::STEPS_W'($urandom_range(255, 200)));
		end else if (pick < 93)
			send_cmd(tpp_pkg::K_DUMP, junk);
		else
			send_cmd($urandom_range(1) ? K_BAD_HI : K_BAD_LO, junk);
	endtask

	initial begin
		int phase;
		int i;
		int phase_pct [4];
		phase_pct = '{0, 71, 32, 0};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// blank canvas, then walk the border with clamping on every side
		send_cmd(tpp_pkg::K_DUMP, 8'h00);
		send_cmd(tpp_pkg::K_MOVE, 8'd5);
		send_cmd(tpp_pkg::K_PEN_DOWN, 8'hFF);
		send_cmd(tpp_pkg::K_MOVE, 8'd0);
		send_cmd(tpp_pkg::K_MOVE, 8'd1);
		send_cmd(tpp_pkg::K_LEFT, 8'h00);
		send_cmd(tpp_pkg::K_MOVE, 8'd3);
		send_cmd(tpp_pkg::K_LEFT, 8'h00);
		send_cmd(tpp_pkg::K_MOVE, 8'd255);
		send_cmd(tpp_pkg::K_LEFT, 8'h00);
		send_cmd(tpp_pkg::K_MOVE, 8'd255);
		send_cmd(tpp_pkg::K_LEFT, 8'h00);
		send_cmd(tpp_pkg::K_MOVE, 8'd255);
		send_cmd(tpp_pkg::K_RIGHT, 8'h00);
		send_cmd(tpp_pkg::K_RIGHT, 8'hFF);
		send_cmd(tpp_pkg::K_RIGHT, 8'h00);
		send_cmd(tpp_pkg::K_RIGHT, 8'h00);
		send_cmd(K_BAD_LO, 8'hFF);
		send_cmd(K_BAD_HI, 8'h00);
		send_cmd(tpp_pkg::K_PEN_UP, 8'h00);
		send_cmd(tpp_pkg::K_RIGHT, 8'h00);
		send_cmd(tpp_pkg::K_MOVE, 8'd7);
		send_cmd(tpp_pkg::K_PEN_UP, 8'hAA);
		send_cmd(tpp_pkg::K_DUMP, 8'h55);

		for (phase = 0; phase < 4; phase++) begin
			idle_pct = phase_pct[phase];
			for (i = 0; i < 88; i++)
				send_random_cmd();
		end
		start <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (GRID + 8) @(posedge clk);

		if (sb.errors == 0 && sb.pending() == 0)
			$display("turtle_pen_plotter_grid_tb OK");
		else
			$display("turtle_pen_plotter_grid_tb NOT OK");
		$finish;
	end

	initial begin
		#(RUN_LIMIT_NS);
		$display("%0t: run limit reached", $time);
		$display("turtle_pen_plotter_grid_tb NOT OK");
		$finish;
	end

endmodule

[sim.f]
rtl/tpp_pkg.sv
rtl/tpp_front.sv
rtl/tpp_queue.sv
rtl/tpp_back.sv
rtl/turtle_pen_plotter_grid.sv
bench/turtle_pen_plotter_grid_tb.sv
